// ===== sv/tfwa_pkg.sv =====
// shared constants, widths and codes for the top-four weight accumulator
// no dependencies; imported by top_four_weight_accumulator and its testbench
`default_nettype none

package tfwa_pkg;

    // list geometry
    localparam int SLOT_COUNT = 4;
    localparam int SHOWN      = 4;
    localparam int IDX_W      = $clog2(SLOT_COUNT);

    // field widths
    localparam int ACT_W  = 2;
    localparam int BONE_W = 16;
    localparam int WGT_W  = 20;
    localparam int MINW_W = 16;
    localparam int FILL_W = 3;

    // normalize arithmetic: total of all slots, restoring divider
    localparam int FRAC_BITS = 16;
    localparam int TOT_W     = WGT_W + $clog2(SLOT_COUNT);
    localparam int REM_W     = TOT_W + 1;
    localparam int QUO_W     = FRAC_BITS + 1;
    localparam int STEP_W    = $clog2(QUO_W);

    // filled counter sized to hold both slot count and saturation value
    localparam int CNT_W    = (IDX_W + 1 > FILL_W) ? IDX_W + 1 : FILL_W;
    localparam int FILL_MAX = (1 << FILL_W) - 1;

    localparam logic [WGT_W-1:0]  WGT_MAX    = {WGT_W{1'b1}};
    localparam logic [MINW_W-1:0] MINW_RESET = MINW_W'(1);

    typedef logic [BONE_W-1:0] t_bone;
    typedef logic [WGT_W-1:0]  t_wgt;
    typedef logic [IDX_W-1:0]  t_idx;

    typedef enum logic [ACT_W-1:0] {
        ACT_ADD   = 2'd0,
        ACT_NORM  = 2'd1,
        ACT_CLEAR = 2'd2
    } t_action;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUM,
        ST_LOAD,
        ST_DIV,
        ST_DONE
    } t_state;

endpackage

`default_nettype wire

// ===== sv/top_four_weight_accumulator.sv =====
// top level of the top-four weight accumulator: sorted slot list, sequencer and
// shared serial divider for normalize; depends on tfwa_pkg
`default_nettype none

// Keeps SLOT_COUNT (bone, weight) slots sorted heaviest first and reports the
// first four after every input beat. For add, clear and the unused action code
// the slot list updates at the accept edge and the result register loads from
// the updated list once it is free. Normalize first sums the slots one per
// cycle, then runs one restoring divider that yields one quotient bit per cycle,
// after a load step for each slot; a normalize is skipped when slot 0 is below
// min_weight, and the divider is skipped when every slot is empty. A new input
// beat is taken while an earlier result still waits in the output register;
// min_weight writes are always taken.
module top_four_weight_accumulator (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    // configuration write
    input  wire                          i_cfg_valid,
    output logic                         o_cfg_ready,
    input  wire  [tfwa_pkg::MINW_W-1:0]  i_cfg_data,
    // input beats
    input  wire                          i_valid,
    output logic                         o_ready,
    input  wire  [tfwa_pkg::ACT_W-1:0]   i_action,
    input  wire  [tfwa_pkg::BONE_W-1:0]  i_bone,
    input  wire  [tfwa_pkg::WGT_W-1:0]   i_amount,
    // result beats
    output logic                         o_valid,
    input  wire                          i_ready,
    output logic [tfwa_pkg::BONE_W-1:0]  o_slot0_bone,
    output logic [tfwa_pkg::BONE_W-1:0]  o_slot1_bone,
    output logic [tfwa_pkg::BONE_W-1:0]  o_slot2_bone,
    output logic [tfwa_pkg::BONE_W-1:0]  o_slot3_bone,
    output logic [tfwa_pkg::WGT_W-1:0]   o_slot0_weight,
    output logic [tfwa_pkg::WGT_W-1:0]   o_slot1_weight,
    output logic [tfwa_pkg::WGT_W-1:0]   o_slot2_weight,
    output logic [tfwa_pkg::WGT_W-1:0]   o_slot3_weight,
    output logic [tfwa_pkg::FILL_W-1:0]  o_filled,
    output logic                         o_usable
);
    import tfwa_pkg::*;

    // state
    t_state              r_state, n_state;
    logic [MINW_W-1:0]   r_min;
    t_bone               r_bone [SLOT_COUNT];
    t_bone               n_bone [SLOT_COUNT];
    t_wgt                r_wgt  [SLOT_COUNT];
    t_wgt                n_wgt  [SLOT_COUNT];
    t_idx                r_idx, n_idx;
    logic [TOT_W-1:0]    r_total, n_total;
    logic [REM_W-1:0]    r_rem, n_rem;
    logic [QUO_W-2:0]    r_quo, n_quo;
    logic [STEP_W-1:0]   r_step, n_step;

    // result register
    logic                r_out_valid, n_out_valid;
    t_bone               r_out_bone [SHOWN];
    t_bone               n_out_bone [SHOWN];
    t_wgt                r_out_wgt  [SHOWN];
    t_wgt                n_out_wgt  [SHOWN];
    logic [FILL_W-1:0]   r_out_fill, n_out_fill;
    logic                r_out_use, n_out_use;

    // add path
    t_bone               add_bone [SLOT_COUNT];
    t_wgt                add_wgt  [SLOT_COUNT];

    logic                in_acc;
    t_wgt                rd_wgt;
    logic                div_ge;
    logic [REM_W-1:0]    div_rem;
    logic [QUO_W-1:0]    div_q;
    t_idx                last_idx;
    logic [CNT_W-1:0]    fill_cnt;

    assign o_cfg_ready = 1'b1;
    assign o_ready     = (r_state == ST_IDLE);
    assign in_acc      = i_valid && o_ready;
    assign rd_wgt      = r_wgt[r_idx];
    assign last_idx    = IDX_W'(SLOT_COUNT - 1);

    // shared divider step: one quotient bit per cycle
    assign div_ge  = (r_rem >= REM_W'(r_total));
    assign div_rem = div_ge ? (r_rem - REM_W'(r_total)) : r_rem;
    assign div_q   = {r_quo, div_ge};

    // add: bump an existing bone and bubble it up, or insert a new pair
    always_comb begin
        logic              amt_ok;
        logic              found;
        t_idx              m;
        t_wgt              m_wgt;
        logic [WGT_W:0]    sum_ext;
        t_wgt              sum_sat;
        logic              k_found;
        t_idx              k;
        logic              p_found;
        t_idx              p;
        logic              do_wr;
        t_idx              dst;
        t_idx              hi;
        t_wgt              new_wgt;

        amt_ok  = (i_amount != '0) && (i_amount >= WGT_W'(r_min));
        found   = 1'b0;
        m       = '0;
        m_wgt   = '0;
        for (int i = 0; i < SLOT_COUNT; i++) begin
            if (!found && r_wgt[i] != '0 && r_bone[i] == i_bone) begin
                found = 1'b1;
                m     = IDX_W'(i);
                m_wgt = r_wgt[i];
            end
        end
        sum_ext = {1'b0, m_wgt} + {1'b0, i_amount};
        sum_sat = sum_ext[WGT_W] ? WGT_MAX : sum_ext[WGT_W-1:0];

        // bubble target: first slot above the match that is strictly lighter
        k_found = 1'b0;
        k       = m;
        for (int i = 0; i < SLOT_COUNT; i++) begin
            if (!k_found && IDX_W'(i) < m && r_wgt[i] < sum_sat) begin
                k_found = 1'b1;
                k       = IDX_W'(i);
            end
        end

        // insert position: first empty slot or first strictly lighter slot
        p_found = 1'b0;
        p       = '0;
        for (int i = 0; i < SLOT_COUNT; i++) begin
            if (!p_found && (r_wgt[i] == '0 || i_amount > r_wgt[i])) begin
                p_found = 1'b1;
                p       = IDX_W'(i);
            end
        end

        do_wr   = amt_ok && (found || p_found);
        dst     = found ? k : p;
        hi      = found ? m : last_idx;
        new_wgt = found ? sum_sat : i_amount;

        for (int j = 0; j < SLOT_COUNT; j++) begin
            add_bone[j] = r_bone[j];
            add_wgt[j]  = r_wgt[j];
        end
        for (int j = 1; j < SLOT_COUNT; j++) begin
            if (do_wr && IDX_W'(j) > dst && IDX_W'(j) <= hi) begin
                add_bone[j] = r_bone[j-1];
                add_wgt[j]  = r_wgt[j-1];
            end
        end
        for (int j = 0; j < SLOT_COUNT; j++) begin
            if (do_wr && IDX_W'(j) == dst) begin
                add_bone[j] = i_bone;
                add_wgt[j]  = new_wgt;
            end
        end
    end

    // filled count from the current list
    always_comb begin
        fill_cnt = '0;
        for (int i = 0; i < SLOT_COUNT; i++) begin
            if (r_wgt[i] != '0) begin
                fill_cnt = CNT_W'(i + 1);
            end
        end
    end

    // sequencer: next state, slot updates and result load
    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_total     = r_total;
        n_rem       = r_rem;
        n_quo       = r_quo;
        n_step      = r_step;
        n_bone      = r_bone;
        n_wgt       = r_wgt;
        n_out_valid = r_out_valid;
        n_out_bone  = r_out_bone;
        n_out_wgt   = r_out_wgt;
        n_out_fill  = r_out_fill;
        n_out_use   = r_out_use;

        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_state = ST_DONE;
                    case (t_action'(i_action))
                        ACT_ADD: begin
                            n_bone = add_bone;
                            n_wgt  = add_wgt;
                        end
                        ACT_NORM: begin
                            if (r_wgt[0] >= WGT_W'(r_min)) begin
                                n_state = ST_SUM;
                                n_idx   = '0;
                                n_total = '0;
                            end
                        end
                        ACT_CLEAR: begin
                            for (int i = 0; i < SLOT_COUNT; i++) begin
                                n_bone[i] = '0;
                                n_wgt[i]  = '0;
                            end
                        end
                        default: begin
                            n_state = ST_DONE;
                        end
                    endcase
                end
            end
            // accumulate the exact total, one slot a cycle
            ST_SUM: begin
                n_total = r_total + TOT_W'(rd_wgt);
                if (r_idx == last_idx) begin
                    n_idx   = '0;
                    n_state = (n_total == '0) ? ST_DONE : ST_LOAD;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            // dividend top bits are the weight itself
            ST_LOAD: begin
                n_rem   = REM_W'(rd_wgt);
                n_quo   = '0;
                n_step  = '0;
                n_state = ST_DIV;
            end
            ST_DIV: begin
                if (r_step == STEP_W'(QUO_W - 1)) begin
                    n_wgt[r_idx] = WGT_W'(div_q);
                    if (div_q == '0) begin
                        n_bone[r_idx] = '0;
                    end
                    if (r_idx == last_idx) begin
                        n_state = ST_DONE;
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        n_state = ST_LOAD;
                    end
                end else begin
                    n_rem  = {div_rem[TOT_W-1:0], 1'b0};
                    n_quo  = div_q[QUO_W-2:0];
                    n_step = r_step + 1'b1;
                end
            end
            // publish the list once the result register is free
            ST_DONE: begin
                if (!r_out_valid || i_ready) begin
                    for (int s = 0; s < SHOWN; s++) begin
                        n_out_bone[s] = '0;
                        n_out_wgt[s]  = '0;
                        if (s < SLOT_COUNT) begin
                            n_out_wgt[s]  = r_wgt[s];
                            n_out_bone[s] = (r_wgt[s] != '0) ? r_bone[s] : '0;
                        end
                    end
                    n_out_fill  = (fill_cnt > CNT_W'(FILL_MAX)) ? FILL_W'(FILL_MAX)
                                                                : FILL_W'(fill_cnt);
                    n_out_use   = (r_wgt[0] >= WGT_W'(r_min));
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control and slot state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_min       <= MINW_RESET;
            r_idx       <= '0;
            r_step      <= '0;
            for (int i = 0; i < SLOT_COUNT; i++) begin
                r_bone[i] <= '0;
                r_wgt[i]  <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_idx       <= n_idx;
            r_step      <= n_step;
            r_bone      <= n_bone;
            r_wgt       <= n_wgt;
            if (i_cfg_valid && o_cfg_ready) begin
                r_min <= i_cfg_data;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_total    <= n_total;
        r_rem      <= n_rem;
        r_quo      <= n_quo;
        r_out_bone <= n_out_bone;
        r_out_wgt  <= n_out_wgt;
        r_out_fill <= n_out_fill;
        r_out_use  <= n_out_use;
    end

    // result ports
    assign o_valid        = r_out_valid;
    assign o_slot0_bone   = r_out_bone[0];
    assign o_slot1_bone   = r_out_bone[1];
    assign o_slot2_bone   = r_out_bone[2];
    assign o_slot3_bone   = r_out_bone[3];
    assign o_slot0_weight = r_out_wgt[0];
    assign o_slot1_weight = r_out_wgt[1];
    assign o_slot2_weight = r_out_wgt[2];
    assign o_slot3_weight = r_out_wgt[3];
    assign o_filled       = r_out_fill;
    assign o_usable       = r_out_use;

endmodule

`default_nettype wire

// ===== sim/top_four_weight_accumulator_tb.sv =====
// self-checking testbench for top_four_weight_accumulator: directed and random beats
// with a beat-level model of the sorted slot list; depends on tfwa_pkg and the block rtl
`default_nettype none

module top_four_weight_accumulator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tfwa_pkg::*;

    // action code with no operation behind it
    localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;
    localparam int PHASES       = 8;
    localparam int PHASE_BEATS  = 120;
    localparam int MAX_REPORTED = 10;

    typedef struct packed {
        logic [ACT_W-1:0] action;
        t_bone            bone;
        t_wgt             amount;
    } beat_t;

    typedef struct packed {
        logic [SHOWN-1:0][BONE_W-1:0] bones;
        logic [SHOWN-1:0][WGT_W-1:0]  wgts;
        logic [FILL_W-1:0]            filled;
        logic                         usable;
    } slot_report_t;

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              i_cfg_valid = 1'b0;
    logic [MINW_W-1:0] i_cfg_data  = '0;
    logic              i_valid     = 1'b0;
    logic [ACT_W-1:0]  i_action    = '0;
    t_bone             i_bone      = '0;
    t_wgt              i_amount    = '0;
    logic              i_ready     = 1'b0;

    logic              o_cfg_ready;
    logic              o_ready;
    logic              o_valid;
    t_bone             o_slot0_bone, o_slot1_bone, o_slot2_bone, o_slot3_bone;
    t_wgt              o_slot0_weight, o_slot1_weight, o_slot2_weight, o_slot3_weight;
    logic [FILL_W-1:0] o_filled;
    logic              o_usable;

    top_four_weight_accumulator DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_action      (i_action),
        .i_bone        (i_bone),
        .i_amount      (i_amount),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_slot0_bone  (o_slot0_bone),
        .o_slot1_bone  (o_slot1_bone),
        .o_slot2_bone  (o_slot2_bone),
        .o_slot3_bone  (o_slot3_bone),
        .o_slot0_weight(o_slot0_weight),
        .o_slot1_weight(o_slot1_weight),
        .o_slot2_weight(o_slot2_weight),
        .o_slot3_weight(o_slot3_weight),
        .o_filled      (o_filled),
        .o_usable      (o_usable)
    );

    // model copy of the slot list and threshold
    t_bone             held_bone [SLOT_COUNT] = '{default: '0};
    t_wgt              held_wgt  [SLOT_COUNT] = '{default: '0};
    logic [MINW_W-1:0] floor_wgt  = MINW_RESET;

    beat_t        pending_beats[$];
    slot_report_t expected_lists[$];
    int           mismatch_count = 0;
    int           send_gap       = 0;
    int           stall_gap      = 0;
    int           idle_pct       = 20;
    bit           quiet          = 1'b0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // apply one beat to the model list and report the list afterwards
    function automatic slot_report_t step_slot_list(input beat_t b);
        slot_report_t     r;
        logic [WGT_W+1:0] sum;
        logic [63:0]      total;
        logic [63:0]      scaled;
        t_wgt             tw;
        t_bone            tb;
        int               i;
        int               j;
        int               pos;
        int               last;
        bit               hit;
        bit               stop;
        bit               placed;
        hit    = 1'b0;
        stop   = 1'b0;
        placed = 1'b0;
        pos    = 0;
        if (b.action == ACT_ADD) begin
            if (b.amount != '0 && b.amount >= WGT_W'(floor_wgt)) begin
                // accumulate onto a filled slot holding the same bone
                for (i = 0; i < SLOT_COUNT; i++) begin
                    if (!hit && !stop) begin
                        if (held_wgt[i] == '0) begin
                            stop = 1'b1;
                        end else if (held_bone[i] == b.bone) begin
                            hit = 1'b1;
                            pos = i;
                            sum = {2'b00, held_wgt[i]} + {2'b00, b.amount};
                            held_wgt[i] = (sum > WGT_MAX) ? WGT_MAX : sum[WGT_W-1:0];
                        end
                    end
                end
                if (hit) begin
                    // bubble up while strictly heavier than the slot above
                    stop = 1'b0;
                    for (j = pos; j >= 1; j--) begin
                        if (!stop) begin
                            if (held_wgt[j] <= held_wgt[j-1]) begin
                                stop = 1'b1;
                            end else begin
                                tw = held_wgt[j];
                                held_wgt[j] = held_wgt[j-1];
                                held_wgt[j-1] = tw;
                                tb = held_bone[j];
                                held_bone[j] = held_bone[j-1];
                                held_bone[j-1] = tb;
                            end
                        end
                    end
                end else begin
                    // first empty slot, or in front of the first lighter one
                    for (i = 0; i < SLOT_COUNT; i++) begin
                        if (!placed) begin
                            if (held_wgt[i] == '0) begin
                                held_wgt[i]  = b.amount;
                                held_bone[i] = b.bone;
                                placed = 1'b1;
                            end else if (b.amount > held_wgt[i]) begin
                                for (j = SLOT_COUNT - 2; j >= i; j--) begin
                                    held_wgt[j+1]  = held_wgt[j];
                                    held_bone[j+1] = held_bone[j];
                                end
                                held_wgt[i]  = b.amount;
                                held_bone[i] = b.bone;
                                placed = 1'b1;
                            end
                        end
                    end
                end
            end
        end else if (b.action == ACT_NORM) begin
            total = '0;
            for (i = 0; i < SLOT_COUNT; i++) begin
                total += 64'(held_wgt[i]);
            end
            if (held_wgt[0] >= WGT_W'(floor_wgt) && total != '0) begin
                for (i = 0; i < SLOT_COUNT; i++) begin
                    scaled = (64'(held_wgt[i]) << FRAC_BITS) / total;
                    held_wgt[i] = scaled[WGT_W-1:0];
                    if (held_wgt[i] == '0) begin
                        held_bone[i] = '0;
                    end
                end
            end
        end else if (b.action == ACT_CLEAR) begin
            for (i = 0; i < SLOT_COUNT; i++) begin
                held_wgt[i]  = '0;
                held_bone[i] = '0;
            end
        end

        // build the visible list
        last = 0;
        for (i = 0; i < SHOWN; i++) begin
            r.bones[i] = '0;
            r.wgts[i]  = '0;
            if (i < SLOT_COUNT) begin
                r.wgts[i]  = held_wgt[i];
                r.bones[i] = (held_wgt[i] != '0) ? held_bone[i] : '0;
            end
        end
        for (i = 0; i < SLOT_COUNT; i++) begin
            if (held_wgt[i] != '0) begin
                last = i + 1;
            end
        end
        r.filled = (last > FILL_MAX) ? FILL_W'(FILL_MAX) : FILL_W'(last);
        r.usable = (held_wgt[0] >= WGT_W'(floor_wgt));
        return r;
    endfunction

    task automatic note_mismatch(input string what, input longint want, input longint got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTED) begin
            $display("mismatch at %0t: %s expected 0x%0h got 0x%0h", $realtime, what, want, got);
        end
    endtask

    // compare one result beat against the oldest expected list
    task automatic check_list(input slot_report_t got);
        slot_report_t want;
        int           i;
        if (expected_lists.size() == 0) begin
            note_mismatch("result with nothing expected, slot0 weight", 0, got.wgts[0]);
        end else begin
            want = expected_lists.pop_front();
            for (i = 0; i < SHOWN; i++) begin
                if (got.bones[i] !== want.bones[i]) begin
                    note_mismatch($sformatf("slot%0d bone", i), want.bones[i], got.bones[i]);
                end
                if (got.wgts[i] !== want.wgts[i]) begin
                    note_mismatch($sformatf("slot%0d weight", i), want.wgts[i], got.wgts[i]);
                end
            end
            if (got.filled !== want.filled) begin
                note_mismatch("filled", want.filled, got.filled);
            end
            if (got.usable !== want.usable) begin
                note_mismatch("usable", want.usable, got.usable);
            end
        end
    endtask

    // input driver: predict on accept, then present the next pending beat
    always @(posedge i_clk) begin : beat_driver
        beat_t nb;
        if (!i_rst_n) begin
            i_valid  <= 1'b0;
            send_gap = 0;
        end else begin
            if (i_valid && o_ready) begin
                nb.action = i_action;
                nb.bone   = i_bone;
                nb.amount = i_amount;
                expected_lists.push_back(step_slot_list(nb));
            end
            if (!i_valid || o_ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    i_valid <= 1'b0;
                end else if (pending_beats.size() > 0) begin
                    nb = pending_beats.pop_front();
                    i_valid  <= 1'b1;
                    i_action <= nb.action;
                    i_bone   <= nb.bone;
                    i_amount <= nb.amount;
                    if (!quiet && $urandom_range(0, 99) < idle_pct) begin
                        send_gap = $urandom_range(1, 6);
                    end
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor with random back-pressure
    always @(posedge i_clk) begin : list_monitor
        slot_report_t got;
        if (!i_rst_n) begin
            i_ready   <= 1'b0;
            stall_gap = 0;
        end else begin
            if (o_valid && i_ready) begin
                got.bones[0] = o_slot0_bone;
                got.bones[1] = o_slot1_bone;
                got.bones[2] = o_slot2_bone;
                got.bones[3] = o_slot3_bone;
                got.wgts[0]  = o_slot0_weight;
                got.wgts[1]  = o_slot1_weight;
                got.wgts[2]  = o_slot2_weight;
                got.wgts[3]  = o_slot3_weight;
                got.filled   = o_filled;
                got.usable   = o_usable;
                check_list(got);
            end
            if (stall_gap > 0) begin
                stall_gap--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
                if (!quiet && $urandom_range(0, 99) < idle_pct) begin
                    stall_gap = $urandom_range(1, 6);
                end
            end
        end
    end

    task automatic queue_beat(input logic [ACT_W-1:0] act, input t_bone bone,
                              input t_wgt amount);
        beat_t b;
        b.action = act;
        b.bone   = bone;
        b.amount = amount;
        pending_beats.push_back(b);
    endtask

    // wait until the sender is empty and every result has come back
    task automatic wait_drained();
        do @(negedge i_clk);
        while (pending_beats.size() != 0 || i_valid || expected_lists.size() != 0);
    endtask

    task automatic write_min_weight(input logic [MINW_W-1:0] value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        floor_wgt = value;
        i_cfg_valid <= 1'b0;
    endtask

    // amounts clustered around the threshold, the extremes and the full range
    function automatic t_wgt pick_amount();
        t_wgt a;
        case ($urandom_range(0, 9))
            0:       a = '0;
            1:       a = WGT_W'(floor_wgt);
            2:       a = (floor_wgt == '0) ? '0 : WGT_W'(floor_wgt) - 1'b1;
            3:       a = WGT_MAX - WGT_W'($urandom_range(0, 255));
            4, 5:    a = WGT_W'($urandom_range(1, 20'h3FFFF));
            6, 7:    a = WGT_W'($urandom());
            8:       a = WGT_W'($urandom_range(1, 255));
            default: a = WGT_W'(floor_wgt) + WGT_W'($urandom_range(0, 20'h1FFFF));
        endcase
        return a;
    endfunction

    // mostly a small pool of bones so that adds hit held slots
    function automatic t_bone pick_bone();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 7) begin
            return BONE_W'($urandom_range(0, 5));
        end else if (sel == 7) begin
            return BONE_W'($urandom_range(16'hFFFE, 16'hFFFF));
        end
        return BONE_W'($urandom());
    endfunction

    function automatic logic [ACT_W-1:0] pick_action();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 80) begin
            return ACT_ADD;
        end else if (sel < 92) begin
            return ACT_NORM;
        end else if (sel < 97) begin
            return ACT_CLEAR;
        end
        return ACT_UNUSED;
    endfunction

    // stimulus sequencer
    initial begin : stimulus
        logic [MINW_W-1:0] setting;
        int                p;
        int                n;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed list walk at the reset threshold
        queue_beat(ACT_ADD,    16'd3,     20'h00000);
        queue_beat(ACT_UNUSED, 16'hFFFF,  20'hFFFFF);
        queue_beat(ACT_NORM,   16'd0,     20'h00000);
        queue_beat(ACT_ADD,    16'd5,     20'h10000);
        queue_beat(ACT_ADD,    16'hFFFF,  20'hFFFFF);
        queue_beat(ACT_ADD,    16'd5,     20'hFFFFF);
        queue_beat(ACT_ADD,    16'd7,     20'h20000);
        queue_beat(ACT_ADD,    16'd9,     20'h08000);
        queue_beat(ACT_ADD,    16'd11,    20'h30000);
        queue_beat(ACT_ADD,    16'd12,    20'h00001);
        queue_beat(ACT_ADD,    16'd7,     20'hF0000);
        queue_beat(ACT_ADD,    16'd11,    20'h40000);
        queue_beat(ACT_NORM,   16'd0,     20'h00000);
        queue_beat(ACT_NORM,   16'hFFFF,  20'hFFFFF);
        queue_beat(ACT_CLEAR,  16'hFFFF,  20'hFFFFF);
        queue_beat(ACT_ADD,    16'd0,     20'h00001);
        queue_beat(ACT_ADD,    16'd2,     20'hFFFFF);
        queue_beat(ACT_NORM,   16'd0,     20'h00000);
        queue_beat(ACT_UNUSED, 16'h5A5A,  20'hA5A5A);
        queue_beat(ACT_CLEAR,  16'd0,     20'h00000);
        wait_drained();

        // zero threshold: zero amount still changes nothing
        write_min_weight(16'h0000);
        queue_beat(ACT_ADD,  16'd4, 20'h00000);
        queue_beat(ACT_ADD,  16'd4, 20'h00001);
        queue_beat(ACT_NORM, 16'd0, 20'h00000);
        wait_drained();

        // top threshold: amounts just below are dropped
        write_min_weight(16'hFFFF);
        queue_beat(ACT_ADD,  16'd6, 20'h0FFFF);
        queue_beat(ACT_ADD,  16'd6, 20'h0FFFE);
        queue_beat(ACT_NORM, 16'd0, 20'h00000);
        queue_beat(ACT_CLEAR, 16'd0, 20'h00000);
        wait_drained();

        // random phases, one threshold each, draining in between
        for (p = 0; p < PHASES; p++) begin
            case (p)
                0:       setting = 16'h0400;
                1:       setting = 16'h0000;
                2:       setting = 16'hFFFF;
                4:       setting = 16'h0001;
                5:       setting = 16'h8000;
                7:       setting = 16'h0010;
                default: setting = MINW_W'($urandom_range(1, 16'hFFFF));
            endcase
            case (p % 4)
                0:       idle_pct = 25;
                1:       idle_pct = 0;
                2:       idle_pct = 50;
                default: idle_pct = 10;
            endcase
            quiet = (p == PHASES - 1);
            write_min_weight(setting);
            for (n = 0; n < PHASE_BEATS; n++) begin
                queue_beat(pick_action(), pick_bone(), pick_amount());
            end
            wait_drained();
        end

        repeat (100) @(posedge i_clk);
        if (mismatch_count == 0 && expected_lists.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // watchdog
    initial begin : watchdog
        #5_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

`default_nettype wire
